/* src/accumulator_alu_booth_multiply_unit_macros.svh */
// Assertion macros for the accumulator ALU block.
// Used by files that assert; they expect clk and arst_n in scope.
`ifndef ACCUMULATOR_ALU_BOOTH_MULTIPLY_UNIT_MACROS_SVH
`define ACCUMULATOR_ALU_BOOTH_MULTIPLY_UNIT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define AABM_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("aabm assertion failed");

// Antecedent implies consequent in the next cycle.
`define AABM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("aabm assertion failed");

`endif

/* src/aabm_pkg.sv */
// Package of the accumulator ALU block: opcodes, widths and shared types.
// No dependencies.
package aabm_pkg;

	localparam int OpW   = 5;
	localparam int ByteW = 8;
	localparam int AccW  = 16;

	localparam logic [OpW-1:0] OP_LOAD   = 5'h09;
	localparam logic [OpW-1:0] OP_READ   = 5'h0B;
	localparam logic [OpW-1:0] OP_CMP_1  = 5'h11;
	localparam logic [OpW-1:0] OP_CMP_2  = 5'h12;
	localparam logic [OpW-1:0] OP_CMP_3  = 5'h13;
	localparam logic [OpW-1:0] OP_CMP_4  = 5'h14;
	localparam logic [OpW-1:0] OP_SHR    = 5'h15;
	localparam logic [OpW-1:0] OP_SHL    = 5'h16;
	localparam logic [OpW-1:0] OP_XOR    = 5'h17;
	localparam logic [OpW-1:0] OP_NOT    = 5'h18;
	localparam logic [OpW-1:0] OP_OR     = 5'h19;
	localparam logic [OpW-1:0] OP_AND    = 5'h1A;
	localparam logic [OpW-1:0] OP_MUL    = 5'h1B;
	localparam logic [OpW-1:0] OP_SUB    = 5'h1D;
	localparam logic [OpW-1:0] OP_ADD    = 5'h1E;

	typedef struct packed {
		logic zero;
		logic carry;
		logic sign;
		logic overflow;
	} flags_t;

	typedef struct packed {
		logic [AccW-1:0]  acc;
		logic [ByteW-1:0] bus;
		flags_t           flags;
	} alu_res_t;

endpackage

/* src/aabm_in_if.sv */
// Input channel of the accumulator ALU: opcode and bus operand.
// Depends on aabm_pkg.
interface aabm_in_if;
	logic                      valid;
	logic                      ready;
	logic [aabm_pkg::OpW-1:0]   operation;
	logic [aabm_pkg::ByteW-1:0] bus_operand;

	modport source(output valid, output operation, output bus_operand, input ready);
	modport sink(input valid, input operation, input bus_operand, output ready);
endinterface

/* src/aabm_out_if.sv */
// Result channel of the accumulator ALU: accumulator, bus byte and flags.
// Depends on aabm_pkg.
interface aabm_out_if;
	logic                      valid;
	logic                      ready;
	logic [aabm_pkg::AccW-1:0]  accumulator_value;
	logic [aabm_pkg::ByteW-1:0] bus_result;
	logic                      zero_flag;
	logic                      carry_flag;
	logic                      sign_flag;
	logic                      overflow_flag;

	modport source(output valid, output accumulator_value, output bus_result,
		output zero_flag, output carry_flag, output sign_flag, output overflow_flag,
		input ready);
	modport sink(input valid, input accumulator_value, input bus_result,
		input zero_flag, input carry_flag, input sign_flag, input overflow_flag,
		output ready);
endinterface

/* src/aabm_booth_mul.sv */
// Signed 8x8 radix-4 Booth multiplier, combinational, exact 16-bit product.
// Depends on aabm_pkg.
module aabm_booth_mul (
	input  logic [aabm_pkg::ByteW-1:0] a,
	input  logic [aabm_pkg::ByteW-1:0] b,
	output logic [aabm_pkg::AccW-1:0]  product
);

	localparam int NumPp = aabm_pkg::ByteW / 2;

	logic [aabm_pkg::AccW-1:0]  a_ext;
	logic [aabm_pkg::ByteW:0]   b_ext;
	logic [aabm_pkg::AccW-1:0]  pp [NumPp];

	// The multiplicand is sign-extended to the full product width, so that
	// twice the most negative value is still represented exactly.
	assign a_ext = {{(aabm_pkg::AccW-aabm_pkg::ByteW){a[aabm_pkg::ByteW-1]}}, a};
	assign b_ext = {b, 1'b0};

	always_comb begin
		for (int i = 0; i < NumPp; i++) begin
			unique case (b_ext[2*i +: 3])
				3'b001, 3'b010: pp[i] = a_ext;
				3'b011:         pp[i] = a_ext << 1;
				3'b100:         pp[i] = -(a_ext << 1);
				3'b101, 3'b110: pp[i] = -a_ext;
				default:        pp[i] = '0;
			endcase
		end
	end

	assign product = pp[0] + (pp[1] << 2) + (pp[2] << 4) + (pp[3] << 6);

endmodule

/* src/aabm_alu.sv */
// Execute logic: next accumulator, bus byte and flags for one request.
// Depends on aabm_pkg and aabm_booth_mul.
module aabm_alu (
	input  logic [aabm_pkg::OpW-1:0]   operation,
	input  logic [aabm_pkg::ByteW-1:0] bus_operand,
	input  logic [aabm_pkg::AccW-1:0]  acc,
	output aabm_pkg::alu_res_t         res
);

	logic [aabm_pkg::ByteW-1:0] a;
	logic [aabm_pkg::ByteW-1:0] b;
	logic [aabm_pkg::AccW-1:0]  product;
	logic [aabm_pkg::AccW-1:0]  acc_next;
	logic                      shift_big;

	assign a = acc[aabm_pkg::ByteW-1:0];
	assign b = bus_operand;
	assign shift_big = |b[aabm_pkg::ByteW-1:3];

	aabm_booth_mul u_mul (
		.a      (a),
		.b      (b),
		.product(product)
	);

	always_comb begin
		acc_next = acc;
		res.bus = b;
		unique case (operation)
			aabm_pkg::OP_ADD: acc_next = {8'h00, a + b};
			aabm_pkg::OP_SUB, aabm_pkg::OP_CMP_1, aabm_pkg::OP_CMP_2,
			aabm_pkg::OP_CMP_3, aabm_pkg::OP_CMP_4: acc_next = {8'h00, a - b};
			aabm_pkg::OP_MUL: acc_next = product;
			aabm_pkg::OP_AND: acc_next = {8'h00, a & b};
			aabm_pkg::OP_OR:  acc_next = {8'h00, a | b};
			aabm_pkg::OP_NOT: acc_next = {8'h00, ~a};
			aabm_pkg::OP_XOR: acc_next = {8'h00, a ^ b};
			aabm_pkg::OP_SHL: acc_next = shift_big ? '0 : {8'h00, a << b[2:0]};
			aabm_pkg::OP_SHR: acc_next = shift_big ? '0 : {8'h00, a >> b[2:0]};
			aabm_pkg::OP_LOAD: acc_next = {8'h00, b};
			aabm_pkg::OP_READ: res.bus = a;
			default: acc_next = acc;
		endcase
		res.acc = acc_next;
		res.flags.zero = (acc_next == '0);
		res.flags.carry = |acc_next[aabm_pkg::AccW-1:aabm_pkg::ByteW];
		res.flags.sign = acc_next[aabm_pkg::ByteW-1];
		res.flags.overflow = |acc_next[aabm_pkg::AccW-1:aabm_pkg::ByteW-1];
	end

endmodule

/* src/accumulator_alu_booth_multiply_unit.sv */
// Accumulator ALU with signed Booth multiply. An accepted request passes
// through the input register and then the result register. Throughput is one
// request per cycle while the result side is ready; the accumulator is
// written when a request moves into the result register, so the next one sees it.
// Asynchronous active-low reset clears the accumulator and both valid bits.
`include "accumulator_alu_booth_multiply_unit_macros.svh"
module accumulator_alu_booth_multiply_unit (
	input logic          clk,
	input logic          arst_n,
	aabm_in_if.sink      in,
	aabm_out_if.source   out
);

	logic                      valid_s1;
	logic [aabm_pkg::OpW-1:0]   op_s1;
	logic [aabm_pkg::ByteW-1:0] operand_s1;
	logic                      valid_s2;
	aabm_pkg::alu_res_t         res_s2;
	logic [aabm_pkg::AccW-1:0]  acc_q;
	aabm_pkg::alu_res_t         res;
	logic                      load_s2;
	logic                      adv_s1;

	assign load_s2 = !valid_s2 || out.ready;
	assign adv_s1 = valid_s1 && load_s2;
	assign in.ready = !valid_s1 || load_s2;

	aabm_alu u_alu (
		.operation  (op_s1),
		.bus_operand(operand_s1),
		.acc        (acc_q),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			acc_q <= '0;
		end else begin
			if (in.ready) begin
				valid_s1 <= in.valid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s1) begin
				acc_q <= res.acc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in.valid && in.ready) begin
			op_s1 <= in.operation;
			operand_s1 <= in.bus_operand;
		end
		if (adv_s1) begin
			res_s2 <= res;
		end
	end

	assign out.valid = valid_s2;
	assign out.accumulator_value = res_s2.acc;
	assign out.bus_result = res_s2.bus;
	assign out.zero_flag = res_s2.flags.zero;
	assign out.carry_flag = res_s2.flags.carry;
	assign out.sign_flag = res_s2.flags.sign;
	assign out.overflow_flag = res_s2.flags.overflow;

	// The delivered accumulator always matches the architectural one.
	`AABM_ASSERT_SAME(a_out_matches_acc, valid_s2, res_s2.acc == acc_q)
	`AABM_ASSERT_NEXT(a_stall_holds_acc, valid_s2 && !out.ready, $stable(acc_q))
	`AABM_ASSERT_NEXT(a_accept_fills_s1, in.valid && in.ready, valid_s1)
	`AABM_ASSERT_NEXT(a_s1_moves_to_s2, adv_s1, valid_s2)

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the accumulator ALU with signed Booth multiply.
// Depends on aabm_pkg, aabm_in_if, aabm_out_if and accumulator_alu_booth_multiply_unit.
// A scoreboard tracks the accumulator, predicts each result and checks them in order.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import aabm_pkg::*;

	localparam int RandomRequests = 900;
	localparam int CycleLimit     = 400000;
	localparam int ReportLimit    = 10;

	class alu_scoreboard;
		logic [AccW-1:0] acc_model;
		alu_res_t        expected_results[$];
		int              mismatches;

		function new();
			acc_model = '0;
			mismatches = 0;
		endfunction

		// Applies one request to the tracked accumulator and returns the expected result.
		function alu_res_t predict_alu(logic [OpW-1:0] op, logic [ByteW-1:0] operand);
			logic [ByteW-1:0] low_byte;
			logic [ByteW-1:0] bus_byte;
			int               mul_a;
			int               mul_b;
			int               product;
			alu_res_t         res;
			low_byte = acc_model[ByteW-1:0];
			bus_byte = operand;
			case (op)
				OP_ADD: begin
					acc_model = {8'h00, 8'(low_byte + operand)};
				end
				OP_SUB, OP_CMP_1, OP_CMP_2, OP_CMP_3, OP_CMP_4: begin
					acc_model = {8'h00, 8'(low_byte - operand)};
				end
				OP_MUL: begin
					mul_a = int'($signed(low_byte));
					mul_b = int'($signed(operand));
					product = mul_a * mul_b;
					acc_model = 16'(product);
				end
				OP_AND: acc_model = {8'h00, low_byte & operand};
				OP_OR:  acc_model = {8'h00, low_byte | operand};
				OP_NOT: acc_model = {8'h00, ~low_byte};
				OP_XOR: acc_model = {8'h00, low_byte ^ operand};
				OP_SHL: begin
					acc_model = (operand >= 8) ? '0 : {8'h00, 8'(low_byte << operand)};
				end
				OP_SHR: begin
					acc_model = (operand >= 8) ? '0 : {8'h00, 8'(low_byte >> operand)};
				end
				OP_LOAD: acc_model = {8'h00, operand};
				OP_READ: bus_byte = low_byte;
				default: begin
				end
			endcase
			res.acc = acc_model;
			res.bus = bus_byte;
			res.flags.zero = (acc_model == 0);
			res.flags.carry = (acc_model > 16'h00FF);
			res.flags.sign = acc_model[7];
			res.flags.overflow = (acc_model > 16'h007F);
			return res;
		endfunction

		function void note_request(logic [OpW-1:0] op, logic [ByteW-1:0] operand);
			expected_results.push_back(predict_alu(op, operand));
		endfunction

		function void check_result(alu_res_t got);
			alu_res_t want;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= ReportLimit)
					$display("mismatch: unexpected result acc=%h bus=%h flags=%b",
						got.acc, got.bus, got.flags);
				return;
			end
			want = expected_results.pop_front();
			if (got.acc !== want.acc || got.bus !== want.bus ||
				got.flags.zero !== want.flags.zero || got.flags.carry !== want.flags.carry ||
				got.flags.sign !== want.flags.sign ||
				got.flags.overflow !== want.flags.overflow) begin
				mismatches++;
				if (mismatches <= ReportLimit)
					$display("mismatch: expected acc=%h bus=%h zcso=%b, got acc=%h bus=%h zcso=%b",
						want.acc, want.bus, want.flags, got.acc, got.bus, got.flags);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   cycle_count;
	bit   sender_burst;
	bit   receiver_burst;

	aabm_in_if  in_ch();
	aabm_out_if out_ch();

	alu_scoreboard sb = new();

	accumulator_alu_booth_multiply_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in(in_ch),
		.out(out_ch)
	);

	logic [OpW-1:0] known_ops[15] = '{OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_NOT, OP_XOR,
		OP_SHL, OP_SHR, OP_LOAD, OP_READ, OP_CMP_1, OP_CMP_2, OP_CMP_3, OP_CMP_4};

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Idle stretches alternate with runs where the side never waits.
	function automatic int draw_wait(ref bit burst);
		if ($urandom_range(0, 19) == 0)
			burst = ~burst;
		return burst ? 0 : $urandom_range(0, 14);
	endfunction

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic send_request(input logic [OpW-1:0] op, input logic [ByteW-1:0] operand);
		int gap;
		gap = draw_wait(sender_burst);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.operation <= op;
		in_ch.bus_operand <= operand;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_request(op, operand);
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_ch.valid <= 1'b0;
		@(negedge clk);
		while (sb.expected_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic send_random_request();
		logic [OpW-1:0]   op;
		logic [ByteW-1:0] operand;
		if ($urandom_range(0, 4) == 0)
			op = OpW'($urandom_range(0, 31));
		else
			op = known_ops[$urandom_range(0, 14)];
		case ($urandom_range(0, 7))
			0: operand = ($urandom_range(0, 1) ? 8'h80 : 8'h7F) ^ {8{$urandom_range(0, 1) == 1}};
			1, 2: operand = ByteW'($urandom_range(0, 9));
			default: operand = ByteW'($urandom_range(0, 255));
		endcase
		send_request(op, operand);
	endtask

	initial begin
		cycle_count = 0;
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	// Result side: stalls at random, then checks each result as it is taken.
	initial begin
		int stall;
		out_ch.ready = 1'b0;
		receiver_burst = 1'b0;
		forever begin
			alu_res_t got;
			stall = draw_wait(receiver_burst);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
			got.acc = out_ch.accumulator_value;
			got.bus = out_ch.bus_result;
			got.flags.zero = out_ch.zero_flag;
			got.flags.carry = out_ch.carry_flag;
			got.flags.sign = out_ch.sign_flag;
			got.flags.overflow = out_ch.overflow_flag;
			sb.check_result(got);
			@(negedge clk);
		end
	end

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.operation = '0;
		in_ch.bus_operand = '0;
		sender_burst = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_request(OP_LOAD, 8'hFF);
		send_request(OP_READ, 8'h00);
		send_request(OP_ADD, 8'h01);
		send_request(OP_LOAD, 8'h7F);
		send_request(OP_ADD, 8'h01);
		send_request(OP_SUB, 8'hFF);
		send_request(OP_CMP_1, 8'h01);
		send_request(OP_CMP_2, 8'h80);
		send_request(OP_CMP_3, 8'hFF);
		send_request(OP_CMP_4, 8'h00);
		// The most negative multiplicand needs a guard bit in a Booth datapath.
		send_request(OP_LOAD, 8'h80);
		send_request(OP_MUL, 8'h80);
		send_request(OP_READ, 8'h55);
		send_request(OP_LOAD, 8'h80);
		send_request(OP_MUL, 8'h7F);
		send_request(OP_MUL, 8'hFF);
		send_request(OP_AND, 8'hF0);
		send_request(OP_OR, 8'h0F);
		send_request(OP_NOT, 8'h00);
		send_request(OP_XOR, 8'hAA);
		send_request(OP_SHL, 8'h03);
		send_request(OP_SHR, 8'h08);
		send_request(OP_SHL, 8'hFF);
		send_request(OP_SHR, 8'h07);
		send_request(5'h1F, 8'h3C);
		drain_results();

		for (int i = 0; i < RandomRequests; i++) begin
			if (i == RandomRequests / 2)
				drain_results();
			send_random_request();
		end

		drain_results();
		repeat (10) @(negedge clk);
		if (sb.mismatches == 0 && sb.expected_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
